// File: rtl/bcg_pkg.sv
// ----------------------------------------------------------------------------
// bcg_pkg: shared types and constants of the bounding cone grower
// Item payloads, fixed point format, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package bcg_pkg;

  // Fixed point fraction bits of all coordinates, radius and height
  localparam int FRAC_BITS = 16;

  localparam logic [30:0] VAL_MAX = 31'h7FFF_FFFF;

  // Reset values
  localparam logic [30:0] RST_RADIUS = 31'd65536;
  localparam logic [23:0] RST_SLOPE  = 24'd65536;
  localparam logic [30:0] RST_HEIGHT = 31'((64'd65536 << FRAC_BITS) / 64'd65536);

  // Configuration register indexes
  localparam logic [2:0] REG_CENTER_X = 3'd0;
  localparam logic [2:0] REG_CENTER_Y = 3'd1;
  localparam logic [2:0] REG_BASE_Z   = 3'd2;
  localparam logic [2:0] REG_INIT_RAD = 3'd3;
  localparam logic [2:0] REG_SLOPE    = 3'd4;

  typedef struct packed {
    logic               start_req;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } vtx_t;

  typedef struct packed {
    logic [30:0] radius_now;
    logic [30:0] height_now;
    logic        grew;
    logic        saturated;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HSET,
    ST_HDIV,
    ST_SQX,
    ST_SQY,
    ST_ROOT,
    ST_DECIDE,
    ST_MUL,
    ST_DIV,
    ST_APPLY,
    ST_FIN
  } state_t;

endpackage

// File: rtl/bcg_vtx_if.sv
// ----------------------------------------------------------------------------
// bcg_vtx_if / bcg_res_if: valid/ready channels of the cone grower
// One item moves at a clock edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface bcg_vtx_if;
  import bcg_pkg::*;
  logic valid;
  logic ready;
  vtx_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bcg_res_if;
  import bcg_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/bounding_cone_grow.sv
// ----------------------------------------------------------------------------
// bounding_cone_grow: grows an upright bounding cone over a vertex stream
// Bit-serial sequencer: squares, root, product and quotient one bit a cycle.
// ----------------------------------------------------------------------------
// Usage:
//  vtx  (sink)  : one vertex per item, with start_req to reload the radius.
//  res  (source): one result item per vertex: radius, height, grew, saturated.
//  cfg_we/cfg_addr/cfg_data: register writes, applied at once; write them
//  only while no vertex is in flight.
// Timing: one vertex at a time. A vertex runs through these steps in order:
//  two squarings, a root, then a shift-add product, a restoring quotient
//  for the inside case and a height quotient when the cone changes (and
//  one more height quotient on reload, before the squarings).
//  Each step runs on a one-bit-per-cycle unit; multiplier and divider are shared.
// vtx.ready is high while the sequencer is idle; a result waiting in the
//  output register does not block the next vertex, which only holds in its
//  last step until the output register is free.
// Reset: synchronous, active high; registers go to their reset values,
//  radius is 1.0 and height is 1.0 / slope; no result is pending.
// ----------------------------------------------------------------------------
module bounding_cone_grow (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_data,
  bcg_vtx_if.sink     vtx,
  bcg_res_if.source   res
);
  import bcg_pkg::*;

  // Configuration
  logic [31:0] center_x, center_y, base_z;
  logic [30:0] initial_radius;
  logic [23:0] slope_tan;

  // Cone state
  logic [30:0] radius, height, old_r;
  logic        satf, reload, dbig, apexf;

  // Vertex offsets
  logic [30:0] ay;
  logic [32:0] z;

  // Shift-add multiplier
  logic [63:0] mcand, acc;
  logic [31:0] mplier;
  // Restoring divider
  logic [63:0] num, quo;
  logic [31:0] den, rem;
  // Digit-by-digit root
  logic [63:0] v;
  logic [31:0] root;
  logic [33:0] srem;

  logic [6:0]  cnt;
  logic [30:0] newr;
  logic        csat;

  state_t state, state_next;

  // Accept-cycle offsets
  logic [32:0] dx, dy, adx, ady;
  always_comb begin
    dx  = {vtx.data.point_x[31], vtx.data.point_x} - {center_x[31], center_x};
    dy  = {vtx.data.point_y[31], vtx.data.point_y} - {center_y[31], center_y};
    adx = dx[32] ? (33'd0 - dx) : dx;
    ady = dy[32] ? (33'd0 - dy) : dy;
  end

  // One step of each serial unit
  logic [63:0] acc_n;
  logic [32:0] rem_sh;
  logic        div_ge;
  logic [31:0] rem_n;
  logic [63:0] quo_n;
  logic [35:0] srem_sh, trial;
  logic        sq_ge;
  logic [35:0] srem_d;
  logic [31:0] root_n;
  always_comb begin
    acc_n   = acc + (mplier[0] ? mcand : 64'd0);
    rem_sh  = {rem, num[63]};
    div_ge  = rem_sh >= {1'b0, den};
    rem_n   = div_ge ? 32'(rem_sh - {1'b0, den}) : rem_sh[31:0];
    quo_n   = {quo[62:0], div_ge};
    srem_sh = {srem, v[63:62]};
    trial   = {2'b00, root, 2'b01};
    sq_ge   = srem_sh >= trial;
    srem_d  = sq_ge ? (srem_sh - trial) : srem_sh;
    root_n  = {root[30:0], sq_ge};
  end

  // Decide, product-end and quotient-end values
  logic        apex;
  logic [30:0] dden;
  logic [63:0] apex_sum;
  logic        quo_big;
  always_comb begin
    apex     = z[31:0] > {1'b0, height};
    dden     = height - z[30:0];
    apex_sum = (acc_n >> FRAC_BITS) + (dbig ? 64'd0 : {32'd0, root});
    quo_big  = |quo_n[63:31];
  end

  logic out_free;
  assign out_free = !res.valid || res.ready;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (vtx.valid) state_next = vtx.data.start_req ? ST_HSET : ST_SQX;
      ST_HSET:   if (slope_tan == 24'd0) state_next = reload ? ST_SQX : ST_FIN;
                 else state_next = ST_HDIV;
      ST_HDIV:   if (cnt == 7'd1) state_next = reload ? ST_SQX : ST_FIN;
      ST_SQX:    if (cnt == 7'd1) state_next = ST_SQY;
      ST_SQY:    if (cnt == 7'd1) state_next = ST_ROOT;
      ST_ROOT:   if (cnt == 7'd1) state_next = ST_DECIDE;
      ST_DECIDE: begin
        if (z[32]) state_next = ST_FIN;
        else if (apex) state_next = ST_MUL;
        else if (dbig || root == 32'd0 || dden == 31'd0) state_next = ST_APPLY;
        else state_next = ST_MUL;
      end
      ST_MUL:    if (cnt == 7'd1) state_next = apexf ? ST_APPLY : ST_DIV;
      ST_DIV:    if (cnt == 7'd1) state_next = ST_APPLY;
      ST_APPLY:  state_next = (apexf || newr > radius) ? ST_HSET : ST_FIN;
      ST_FIN:    if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    vtx.ready = (state == ST_IDLE);
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x       <= 32'd0;
      center_y       <= 32'd0;
      base_z         <= 32'd0;
      initial_radius <= RST_RADIUS;
      slope_tan      <= RST_SLOPE;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_CENTER_X: center_x       <= cfg_data;
        REG_CENTER_Y: center_y       <= cfg_data;
        REG_BASE_Z:   base_z         <= cfg_data;
        REG_INIT_RAD: initial_radius <= cfg_data[30:0];
        REG_SLOPE:    slope_tan      <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // Sequencer datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      radius    <= RST_RADIUS;
      height    <= RST_HEIGHT;
      res.valid <= 1'b0;
      reload    <= 1'b0;
      satf      <= 1'b0;
    end else begin
      state <= state_next;
      // output register: load in the last step, clear once taken
      if (state == ST_FIN && out_free) res.valid <= 1'b1;
      else if (res.ready) res.valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (vtx.valid) begin
            ay     <= ady[30:0];
            dbig   <= adx[32] | adx[31] | ady[32] | ady[31];
            z      <= {vtx.data.point_z[31], vtx.data.point_z} - {base_z[31], base_z};
            satf   <= 1'b0;
            reload <= vtx.data.start_req;
            old_r  <= vtx.data.start_req ? initial_radius : radius;
            if (vtx.data.start_req) radius <= initial_radius;
            mcand  <= {33'd0, adx[30:0]};
            mplier <= {1'b0, adx[30:0]};
            acc    <= 64'd0;
            cnt    <= 7'd31;
          end
        end
        ST_HSET: begin
          if (slope_tan == 24'd0) begin
            height <= VAL_MAX;
            satf   <= 1'b1;
            reload <= 1'b0;
          end else begin
            num <= {33'd0, radius} << FRAC_BITS;
            den <= {8'd0, slope_tan};
            rem <= 32'd0;
            quo <= 64'd0;
            cnt <= 7'd64;
          end
        end
        ST_HDIV: begin
          num <= num << 1;
          rem <= rem_n;
          quo <= quo_n;
          // on reload the squaring follows and needs its own count
          if (cnt == 7'd1 && reload) cnt <= 7'd31;
          else cnt <= cnt - 7'd1;
          if (cnt == 7'd1) begin
            reload <= 1'b0;
            if (quo_big) begin
              height <= VAL_MAX;
              satf   <= 1'b1;
            end else begin
              height <= quo_n[30:0];
            end
          end
        end
        ST_SQX, ST_SQY, ST_MUL: begin
          acc <= acc_n;
          if (cnt != 7'd1) begin
            mcand  <= mcand << 1;
            mplier <= mplier >> 1;
            cnt    <= cnt - 7'd1;
          end else if (state == ST_SQX) begin
            mcand  <= {33'd0, ay};
            mplier <= {1'b0, ay};
            cnt    <= 7'd31;
          end else if (state == ST_SQY) begin
            v    <= acc_n;
            root <= 32'd0;
            srem <= 34'd0;
            cnt  <= 7'd32;
          end else if (apexf) begin
            if (dbig || apex_sum > {33'd0, VAL_MAX}) begin
              newr <= VAL_MAX;
              csat <= 1'b1;
            end else begin
              newr <= apex_sum[30:0];
              csat <= 1'b0;
            end
          end else begin
            num <= acc_n;
            den <= {1'b0, dden};
            rem <= 32'd0;
            quo <= 64'd0;
            cnt <= 7'd64;
          end
        end
        ST_ROOT: begin
          v    <= v << 2;
          srem <= srem_d[33:0];
          root <= root_n;
          cnt  <= cnt - 7'd1;
        end
        ST_DECIDE: begin
          apexf <= apex;
          if (apex) begin
            mcand  <= {32'd0, z[31:0]};
            mplier <= {8'd0, slope_tan};
            acc    <= 64'd0;
            cnt    <= 7'd24;
          end else if (dbig) begin
            newr <= VAL_MAX;
            csat <= 1'b1;
          end else if (root == 32'd0) begin
            newr <= 31'd0;
            csat <= 1'b0;
          end else if (dden == 31'd0) begin
            newr <= VAL_MAX;
            csat <= 1'b1;
          end else begin
            mcand  <= {33'd0, height};
            mplier <= root;
            acc    <= 64'd0;
            cnt    <= 7'd32;
          end
        end
        ST_DIV: begin
          num <= num << 1;
          rem <= rem_n;
          quo <= quo_n;
          cnt <= cnt - 7'd1;
          if (cnt == 7'd1) begin
            newr <= quo_big ? VAL_MAX : quo_n[30:0];
            csat <= quo_big;
          end
        end
        ST_APPLY: begin
          if (apexf || newr > radius) begin
            radius <= newr;
            satf   <= satf | csat;
          end else begin
            satf <= 1'b0;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            res.data.radius_now <= radius;
            res.data.height_now <= height;
            res.data.grew       <= radius > old_r;
            res.data.saturated  <= satf;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
